// ===== hw/rtl/dtr_pkg.sv =====
// ----------------------------------------------------------------------------
// dtr_pkg: shared types and constants for the DC throttle ramp/reversal unit
// Holds the mode encoding, configuration register indexes, reset values and
// the configuration bundle passed between the register file and the core.
// ----------------------------------------------------------------------------
package dtr_pkg;

    // Default width of the PWM power value.
    localparam int POWER_BITS_DEF = 10;

    // Configuration register widths.
    localparam int RAMP_BITS   = 10;
    localparam int INTV_BITS   = 10;
    localparam int SETTLE_BITS = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;

    // Tick counter: one bit wider than the interval so it can exceed it.
    localparam int TICK_BITS = INTV_BITS + 1;
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_STEP       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UPDATE_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_UPDATES  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [RAMP_BITS-1:0]   RAMP_STEP_RST       = 10'd500;
    localparam logic [INTV_BITS-1:0]   UPDATE_INTERVAL_RST = 10'd50;
    localparam logic [SETTLE_BITS-1:0] SETTLE_UPDATES_RST  = 8'd10;

    // Drive mode; the encoding is also the reported phase.
    typedef enum logic [1:0] {
        MODE_RUNNING  = 2'd0,
        MODE_STOPPING = 2'd1,
        MODE_STOPPED  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [RAMP_BITS-1:0]   ramp_step;
        logic [INTV_BITS-1:0]   update_interval;
        logic [SETTLE_BITS-1:0] settle_updates;
    } t_cfg;

endpackage

// ===== hw/rtl/dc_throttle_ramp_reversal_unit.sv =====
// ----------------------------------------------------------------------------
// dc_throttle_ramp_reversal_unit: ramped DC throttle with safe reversal
// Top level: input register, update core, result register, config registers.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the slave stream is one millisecond tick carrying the
// wanted direction and PWM power. Every tick yields exactly one result
// transfer on the master stream with the current power, direction, a changed
// flag and the drive phase (running, stopping, stopped).
// Configuration (ramp step, update interval, settle count) is written through
// the cfg channel, which is always ready; writes to unused indexes are
// dropped. Write it only while the block is idle.
// An accepted tick is held in the input register, the update step runs in the
// logic between it and the result register, and the result is offered from
// the result register. Throughput is one tick per cycle while the receiver
// takes each result, set by the update of the state registers in the core on
// every step.
// Reset (synchronous, active low) empties both registers, loads the default
// configuration and puts the drive in the stopped phase, forward, power zero.
// When the receiver stalls, the result is held; the input register can still
// take one more tick, after which o_s_tready drops until the result drains.
// ----------------------------------------------------------------------------
module dc_throttle_ramp_reversal_unit
    import dtr_pkg::*;
#(
    parameter int POWER_BITS = POWER_BITS_DEF,
    localparam int IN_BITS   = ((POWER_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_BITS  = ((POWER_BITS + 4 + 7) / 8) * 8
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Slave stream. tdata from bit 0: target_forward, target_power.
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [IN_BITS-1:0]       i_s_tdata,
    // Master stream. tdata from bit 0: power_out, forward_out, changed, phase.
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_BITS-1:0]      o_m_tdata,
    // Configuration write channel.
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg cfg;

    // Input register.
    logic                  r_in_valid;
    logic                  r_in_fwd;
    logic [POWER_BITS-1:0] r_in_pow;

    // Result register.
    logic                  r_out_valid;
    logic [POWER_BITS-1:0] r_out_power;
    logic                  r_out_fwd;
    logic                  r_out_changed;
    logic [1:0]            r_out_phase;

    logic                  out_free;
    logic                  step;
    logic                  in_take;

    logic [POWER_BITS-1:0] core_power;
    logic                  core_fwd;
    logic                  core_changed;
    logic [1:0]            core_phase;

    // The result register can load when empty or when its transfer completes.
    assign out_free   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign in_take    = i_s_tvalid && o_s_tready;

    dtr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dtr_core #(
        .POWER_BITS (POWER_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_step     (step),
        .i_want_fwd (r_in_fwd),
        .i_want_pow (r_in_pow),
        .o_power    (core_power),
        .o_forward  (core_fwd),
        .o_changed  (core_changed),
        .o_phase    (core_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_fwd <= i_s_tdata[0];
            r_in_pow <= i_s_tdata[POWER_BITS:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_power   <= core_power;
            r_out_fwd     <= core_fwd;
            r_out_changed <= core_changed;
            r_out_phase   <= core_phase;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_BITS'({r_out_phase, r_out_changed, r_out_fwd, r_out_power});

endmodule

// ===== hw/rtl/dtr_cfg.sv =====
// ----------------------------------------------------------------------------
// dtr_cfg: configuration register file
// Three writable registers selected by index; writes to unused indexes are
// dropped. The port is always ready.
// ----------------------------------------------------------------------------
module dtr_cfg
    import dtr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_step       <= RAMP_STEP_RST;
            r_cfg.update_interval <= UPDATE_INTERVAL_RST;
            r_cfg.settle_updates  <= SETTLE_UPDATES_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RAMP_STEP: begin
                    r_cfg.ramp_step <= i_cfg_data[RAMP_BITS-1:0];
                end
                CFG_UPDATE_INTERVAL: begin
                    r_cfg.update_interval <= i_cfg_data[INTV_BITS-1:0];
                end
                CFG_SETTLE_UPDATES: begin
                    r_cfg.settle_updates <= i_cfg_data[SETTLE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/dtr_core.sv =====
// ----------------------------------------------------------------------------
// dtr_core: throttle state and update step
// Holds mode, drive power, direction, settle counter and tick counter. On a
// step it advances the tick counter and, when the interval is exceeded, runs
// one update. The after-step state is presented combinationally.
// ----------------------------------------------------------------------------
module dtr_core
    import dtr_pkg::*;
#(
    parameter int POWER_BITS = POWER_BITS_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_step,
    input  logic                  i_want_fwd,
    input  logic [POWER_BITS-1:0] i_want_pow,
    output logic [POWER_BITS-1:0] o_power,
    output logic                  o_forward,
    output logic                  o_changed,
    output logic [1:0]            o_phase
);

    // Width wide enough to compare a power gap against the ramp step.
    localparam int CMP_BITS = (POWER_BITS > RAMP_BITS) ? POWER_BITS : RAMP_BITS;

    t_mode                  r_mode,    n_mode;
    logic [POWER_BITS-1:0]  r_power,   n_power;
    logic                   r_fwd,     n_fwd;
    logic [SETTLE_BITS-1:0] r_settle,  n_settle;
    logic [TICK_BITS-1:0]   r_elapsed, n_elapsed;

    logic [TICK_BITS-1:0]   tick_inc;
    logic                   do_update;
    logic [POWER_BITS-1:0]  goal;
    logic [POWER_BITS-1:0]  gap;
    logic [POWER_BITS-1:0]  move;
    logic [POWER_BITS-1:0]  ramped;
    logic                   moved;
    logic                   changed;

    // Single ramp unit; running aims at the target, stopping aims at zero.
    always_comb begin
        goal = (r_mode == MODE_RUNNING) ? i_want_pow : '0;
        gap  = (r_power > goal) ? (r_power - goal) : (goal - r_power);
        if (CMP_BITS'(gap) < CMP_BITS'(i_cfg.ramp_step)) begin
            move = gap;
        end else begin
            move = POWER_BITS'(i_cfg.ramp_step);
        end
        ramped = (r_power < goal) ? (r_power + move) : (r_power - move);
        moved  = (move != '0);
    end

    always_comb begin
        tick_inc  = (r_elapsed < TICK_MAX) ? (r_elapsed + 1'b1) : r_elapsed;
        do_update = (tick_inc > {1'b0, i_cfg.update_interval});

        n_mode    = r_mode;
        n_power   = r_power;
        n_fwd     = r_fwd;
        n_settle  = r_settle;
        n_elapsed = tick_inc;
        changed   = 1'b0;

        if (do_update) begin
            n_elapsed = '0;
            case (r_mode)
                MODE_RUNNING: begin
                    if (r_fwd != i_want_fwd) begin
                        changed = 1'b1;
                        n_mode  = MODE_STOPPING;
                    end else begin
                        changed = moved;
                        n_power = ramped;
                    end
                end
                MODE_STOPPING: begin
                    changed = moved;
                    n_power = ramped;
                    if (!moved) begin
                        n_settle = i_cfg.settle_updates;
                        n_mode   = MODE_STOPPED;
                    end
                end
                default: begin
                    if (r_settle != '0) begin
                        n_settle = r_settle - 1'b1;
                    end else if (r_fwd != i_want_fwd || r_power != i_want_pow) begin
                        changed  = 1'b1;
                        n_fwd    = i_want_fwd;
                        n_power  = '0;
                        n_mode   = MODE_RUNNING;
                        n_settle = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_STOPPED;
            r_power   <= '0;
            r_fwd     <= 1'b1;
            r_settle  <= '0;
            r_elapsed <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_power   <= n_power;
            r_fwd     <= n_fwd;
            r_settle  <= n_settle;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_power   = n_power;
    assign o_forward = n_fwd;
    assign o_changed = changed;
    assign o_phase   = (n_mode == MODE_RUNNING || n_mode == MODE_STOPPING) ?
                       n_mode : MODE_STOPPED;

endmodule
